// File: rtl/sitda_pkg.sv
// Shared types and constants of the signed integer to decimal ASCII unit.
// No dependencies; used by every module under rtl.
package sitda_pkg;

   localparam int DEFAULT_VALUE_BITS = 32;
   localparam int CHAR_BITS          = 8;
   localparam int LENGTH_BITS        = 4;
   localparam int DIGIT_BITS         = 4;

   localparam logic [CHAR_BITS-1:0]   CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_BITS-1:0]   CHAR_MINUS = 8'h2D;
   localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = 4'd15;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   // One command to every cell of the digit chain.
   typedef struct packed {
      logic clear;
      logic bit_shift;
      logic digit_shift;
   } cell_ctrl_type;

endpackage

// File: rtl/signed_int_to_decimal_ascii_unit.sv
// Top level: signed integer to decimal ASCII text, one character per beat.
// Depends on sitda_pkg and sitda_digit_chain.
//
// Usage:
//   req_* : one beat carries one signed VALUE_BITS integer in req_tdata.
//   rsp_* : one beat per character, most significant first: '-' for a
//           negative value, then the digits without leading zeros ('0' for
//           zero). rsp_tlast marks the final character, which also carries
//           the character count (saturating at 15); other beats carry 0.
// Sequence:
//   After the input beat, shift-and-add-3 runs through the digit cells for
//   each of the VALUE_BITS bits, then leading zero digits are dropped one
//   per cycle and one more step ends the scan, then the characters follow
//   at one per cycle while rsp_tready does not hold them back.
//   req_tready is high only while no conversion is in progress; the last
//   character may still wait in the output register.
// Reset clears the controller and the output valid; no character is lost
// or repeated when rsp_tready is held low, the unit just waits.
module signed_int_to_decimal_ascii_unit
   import sitda_pkg::*;
#(
   parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((VALUE_BITS+7)/8)*8-1:0]     req_tdata,   // [VALUE_BITS-1:0] value
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [15:0]                         rsp_tdata,   // [7:0] char_code, [11:8] length
   output logic                                rsp_tlast    // last
);

   localparam int NumDigits = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
   localparam int CntBits   = $clog2(VALUE_BITS);
   localparam int RemBits   = $clog2(NumDigits + 1);
   localparam int TotBits   = $clog2(NumDigits + 2);

   state_type                 state_ff, state_in;
   logic [VALUE_BITS-1:0]     mag_ff, mag_in;
   logic                      neg_ff, neg_in;
   logic [CntBits-1:0]        cnt_ff, cnt_in;
   logic [RemBits-1:0]        rem_ff, rem_in;
   logic [LENGTH_BITS-1:0]    len_ff, len_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]      rsp_char_ff, rsp_char_in;
   logic [LENGTH_BITS-1:0]    rsp_len_ff, rsp_len_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic [VALUE_BITS-1:0]     value;
   logic                      rsp_free;
   logic [TotBits-1:0]        total;
   logic [DIGIT_BITS-1:0]     top_digit;
   cell_ctrl_type             cell_ctrl;

   assign value    = req_tdata[VALUE_BITS-1:0];
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign total    = TotBits'(rem_ff) + TotBits'(neg_ff);

   sitda_digit_chain #(
      .NUM_DIGITS (NumDigits)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (cell_ctrl),
      .bit_in    (mag_ff[VALUE_BITS-1]),
      .top_digit (top_digit)
   );

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      len_in       = len_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in  = rsp_char_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_last_in  = rsp_last_ff;
      cell_ctrl    = '0;
      req_tready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               neg_in          = value[VALUE_BITS-1];
               mag_in          = value[VALUE_BITS-1] ? ~value + 1'b1 : value;
               cnt_in          = CntBits'(VALUE_BITS - 1);
               cell_ctrl.clear = 1'b1;
               state_in        = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cell_ctrl.bit_shift = 1'b1;
            mag_in              = {mag_ff[VALUE_BITS-2:0], 1'b0};
            cnt_in              = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               rem_in   = RemBits'(NumDigits);
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (top_digit == '0 && rem_ff > RemBits'(1)) begin
               cell_ctrl.digit_shift = 1'b1;
               rem_in                = rem_ff - 1'b1;
            end else begin
               len_in   = (total > TotBits'(LENGTH_MAX)) ? LENGTH_MAX
                                                         : LENGTH_BITS'(total);
               state_in = neg_ff ? ST_SIGN : ST_DIGITS;
            end
         end
         ST_SIGN: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_MINUS;
               rsp_last_in  = 1'b0;
               rsp_len_in   = '0;
               state_in     = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (rsp_free) begin
               rsp_valid_in          = 1'b1;
               rsp_char_in           = CHAR_ZERO + CHAR_BITS'(top_digit);
               rsp_last_in           = (rem_ff == RemBits'(1));
               rsp_len_in            = (rem_ff == RemBits'(1)) ? len_ff : '0;
               cell_ctrl.digit_shift = 1'b1;
               rem_in                = rem_ff - 1'b1;
               if (rem_ff == RemBits'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      cnt_ff      <= cnt_in;
      rem_ff      <= rem_in;
      len_ff      <= len_in;
      rsp_char_ff <= rsp_char_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'b0000, rsp_len_ff, rsp_char_ff};

   a_last_has_length: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[11:8] != 4'd0)
      else $error("last beat without a length");

   a_inner_no_length: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[11:8] == 4'd0)
      else $error("length on a beat that is not last");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[7:0] == CHAR_MINUS |-> !rsp_tlast)
      else $error("minus sign flagged as last");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_CONVERT && !req_tready)
      else $error("accepted beat did not start a conversion");

endmodule

// File: rtl/sitda_digit_cell.sv
// One BCD digit cell: add-3 correction and bit shift, whole-digit shift, or clear.
// Depends on sitda_pkg.
module sitda_digit_cell
   import sitda_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctrl_type         ctrl,
   input  logic                  carry_in,
   input  logic [DIGIT_BITS-1:0] digit_prev,
   output logic                  carry_out,
   output logic [DIGIT_BITS-1:0] digit
);

   logic [DIGIT_BITS-1:0] digit_ff;
   logic [DIGIT_BITS-1:0] digit_in;
   logic [DIGIT_BITS-1:0] adjusted;

   assign adjusted  = (digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;
   assign carry_out = adjusted[DIGIT_BITS-1];
   assign digit     = digit_ff;

   always_comb begin
      digit_in = digit_ff;
      if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.bit_shift) begin
         digit_in = {adjusted[DIGIT_BITS-2:0], carry_in};
      end else if (ctrl.digit_shift) begin
         digit_in = digit_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff <= '0;
      end else begin
         digit_ff <= digit_in;
      end
   end

endmodule

// File: rtl/sitda_digit_chain.sv
// Row of BCD digit cells, least significant at index 0; carries and digits
// move toward the top cell. Depends on sitda_pkg and sitda_digit_cell.
module sitda_digit_chain
   import sitda_pkg::*;
#(
   parameter int NUM_DIGITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctrl_type         ctrl,
   input  logic                  bit_in,
   output logic [DIGIT_BITS-1:0] top_digit
);

   logic [NUM_DIGITS:0]   carry;
   logic [DIGIT_BITS-1:0] digits [NUM_DIGITS+1];

   assign carry[0]  = bit_in;
   assign digits[0] = '0;
   assign top_digit = digits[NUM_DIGITS];

   for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
      sitda_digit_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .carry_in   (carry[i]),
         .digit_prev (digits[i]),
         .carry_out  (carry[i+1]),
         .digit      (digits[i+1])
      );
   end

endmodule
